FILE: rtl/three_level_priority_ticket_queue_assert.svh
// Assertion macros used by the checker of the ticket queue.
`ifndef THREE_LEVEL_PRIORITY_TICKET_QUEUE_ASSERT_SVH
`define THREE_LEVEL_PRIORITY_TICKET_QUEUE_ASSERT_SVH

// Same-cycle implication.
`define TLPQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TLPQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/tlpq_pkg.sv
package tlpq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF     = 16;
	localparam int NUM_Q           = 3;

	localparam int FUNC_W   = 2;
	localparam int FID_W    = 16;
	localparam int PRIO_W   = 3;
	localparam int TIME_W   = 17;
	localparam int STATUS_W = 3;
	localparam int FPRIO_W  = 2;
	localparam int IN_W     = 40;
	localparam int OUT_W    = 40;

	typedef enum logic [FUNC_W-1:0] {
		FN_REGISTER = 2'd0,
		FN_REPRIO   = 2'd1,
		FN_DEQUEUE  = 2'd2,
		FN_SEARCH   = 2'd3
	} func_t;

	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_PRIO  = 3'd4;

	localparam logic [PRIO_W-1:0] ALTO  = 3'd1;
	localparam logic [PRIO_W-1:0] MEDIO = 3'd2;
	localparam logic [PRIO_W-1:0] BAJO  = 3'd3;

	typedef struct packed {
		logic shift;
		logic shift_all;
	} cell_ctl_t;

endpackage

FILE: rtl/tlpq_cell.sv
module tlpq_cell #(
	parameter int ID_BITS = tlpq_pkg::ID_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmp_en,
	input  logic [ID_BITS-1:0]          key,
	input  logic                        occ,
	input  tlpq_pkg::cell_ctl_t         ctl,
	input  logic                        load,
	input  logic [ID_BITS-1:0]          load_id,
	input  logic [tlpq_pkg::TIME_W-1:0] load_time,
	input  logic [ID_BITS-1:0]          nb_id,
	input  logic [tlpq_pkg::TIME_W-1:0] nb_time,
	input  logic                        prior_in,
	output logic [ID_BITS-1:0]          id,
	output logic [tlpq_pkg::TIME_W-1:0] tm,
	output logic                        hit,
	output logic                        first,
	output logic                        prior_out
);

	logic [ID_BITS-1:0]          id_q;
	logic [tlpq_pkg::TIME_W-1:0] time_q;
	logic                        hit_q;

	assign id        = id_q;
	assign tm        = time_q;
	assign hit       = hit_q;
	assign prior_out = prior_in | hit_q;
	assign first     = hit_q & ~prior_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmp_en) begin
			hit_q <= occ && (id_q == key);
		end
	end

	// load wins over shift: the tail of a move lands here
	always_ff @(posedge clk) begin
		if (load) begin
			id_q   <= load_id;
			time_q <= load_time;
		end else if (ctl.shift && (ctl.shift_all || prior_out)) begin
			id_q   <= nb_id;
			time_q <= nb_time;
		end
	end

endmodule

FILE: rtl/three_level_priority_ticket_queue.sv
// Three FIFO ticket queues (high, medium, low) held in rows of cells, one
// command word in, one result word out per command. In the cycle a command
// is accepted every cell compares its ticket ID against the incoming one
// and registers the hit; in the EXEC state the first hit is resolved
// along the cell chain, the rows shift or load, and the result is written
// to the output register. s_tready is high only between commands; a result
// may wait in the output register while the next command is taken, but
// EXEC holds until that register is free. Entry contents are undefined
// after reset; the fill counts, hit flags, state and valid flag are cleared.
module three_level_priority_ticket_queue #(
	parameter int QUEUE_DEPTH = tlpq_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = tlpq_pkg::ID_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// func[1:0], ticket_id[17:2], new_priority[20:18], reg_time[37:21]
	input  logic [tlpq_pkg::IN_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// status[2:0], found_id[18:3], found_priority[20:19], found_time[37:21]
	output logic [tlpq_pkg::OUT_W-1:0] m_tdata
);

	localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
	localparam int KeepW = (ID_BITS < tlpq_pkg::FID_W) ? ID_BITS : tlpq_pkg::FID_W;
	localparam int NumQ  = tlpq_pkg::NUM_Q;
	localparam int TimeW = tlpq_pkg::TIME_W;
	localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t                           state_q;
	tlpq_pkg::func_t                  func_q;
	logic [ID_BITS-1:0]               key_q;
	logic [tlpq_pkg::PRIO_W-1:0]      np_q;
	logic [TimeW-1:0]                 time_q;
	logic [CntW-1:0]                  cnt_q [NumQ];
	logic [CntW-1:0]                  cnt_d [NumQ];
	logic                             m_valid_q;
	logic [tlpq_pkg::OUT_W-1:0]       m_data_q;

	logic                             accept;
	logic                             exec_go;
	logic [tlpq_pkg::FID_W-1:0]       in_id;
	logic [ID_BITS-1:0]               key_in;

	logic [ID_BITS-1:0]               c_id    [NumQ][QUEUE_DEPTH];
	logic [TimeW-1:0]                 c_time  [NumQ][QUEUE_DEPTH];
	logic                             c_hit   [NumQ][QUEUE_DEPTH];
	logic                             c_first [NumQ][QUEUE_DEPTH];
	logic                             prior   [NumQ*QUEUE_DEPTH+1];

	tlpq_pkg::cell_ctl_t              row_ctl  [NumQ];
	logic                             row_load [NumQ];
	logic [CntW-1:0]                  load_pos [NumQ];
	logic [ID_BITS-1:0]               load_id;
	logic [TimeW-1:0]                 load_time;

	logic                             row_hit [NumQ];
	logic                             found;
	logic [1:0]                       fq;
	logic                             dq_any;
	logic [1:0]                       dq;
	logic [ID_BITS-1:0]               e_id;
	logic [TimeW-1:0]                 e_time;
	logic [1:0]                       tq;

	logic [tlpq_pkg::STATUS_W-1:0]    res_status;
	logic [ID_BITS-1:0]               res_id;
	logic [tlpq_pkg::FPRIO_W-1:0]     res_prio;
	logic [TimeW-1:0]                 res_time;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign exec_go  = (state_q == ST_EXEC) && (!m_valid_q || m_tready);
	assign in_id    = s_tdata[17:2];
	assign key_in   = ID_BITS'(in_id[KeepW-1:0]);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	assign prior[0] = 1'b0;

	for (genvar r = 0; r < NumQ; r++) begin : g_row
		for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
			logic [ID_BITS-1:0]  nb_id;
			logic [TimeW-1:0]    nb_time;
			tlpq_pkg::cell_ctl_t ctl;
			logic                occ;
			logic                load;

			if (i < QUEUE_DEPTH - 1) begin : g_nb
				assign nb_id   = c_id[r][i+1];
				assign nb_time = c_time[r][i+1];
			end else begin : g_tail
				assign nb_id   = c_id[r][i];
				assign nb_time = c_time[r][i];
			end

			assign occ  = CntW'(i) < cnt_q[r];
			assign ctl  = exec_go ? row_ctl[r] : '0;
			assign load = exec_go && row_load[r] && (load_pos[r] == CntW'(i));

			tlpq_cell #(
				.ID_BITS(ID_BITS)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cmp_en   (accept),
				.key      (key_in),
				.occ      (occ),
				.ctl      (ctl),
				.load     (load),
				.load_id  (load_id),
				.load_time(load_time),
				.nb_id    (nb_id),
				.nb_time  (nb_time),
				.prior_in (prior[r*QUEUE_DEPTH+i]),
				.id       (c_id[r][i]),
				.tm       (c_time[r][i]),
				.hit      (c_hit[r][i]),
				.first    (c_first[r][i]),
				.prior_out(prior[r*QUEUE_DEPTH+i+1])
			);
		end
	end

	always_comb begin
		e_id   = '0;
		e_time = '0;
		for (int r = 0; r < NumQ; r++) begin
			row_hit[r] = 1'b0;
			for (int i = 0; i < QUEUE_DEPTH; i++) begin
				row_hit[r] = row_hit[r] | c_hit[r][i];
				if (c_first[r][i]) begin
					e_id   = e_id | c_id[r][i];
					e_time = e_time | c_time[r][i];
				end
			end
		end
	end

	always_comb begin
		found  = 1'b0;
		fq     = 2'd0;
		dq_any = 1'b0;
		dq     = 2'd0;
		for (int r = NumQ - 1; r >= 0; r--) begin
			if (row_hit[r]) begin
				found = 1'b1;
				fq    = 2'(r);
			end
			if (cnt_q[r] != '0) begin
				dq_any = 1'b1;
				dq     = 2'(r);
			end
		end
	end

	always_comb begin
		res_status = tlpq_pkg::ST_OK;
		res_id     = '0;
		res_prio   = '0;
		res_time   = '0;
		load_id    = key_q;
		load_time  = time_q;
		tq         = 2'(np_q - tlpq_pkg::ALTO);
		for (int r = 0; r < NumQ; r++) begin
			cnt_d[r]    = cnt_q[r];
			row_ctl[r]  = '0;
			row_load[r] = 1'b0;
			load_pos[r] = cnt_q[r];
		end
		case (func_q)
			tlpq_pkg::FN_REGISTER: begin
				if (cnt_q[2] == CntFull) begin
					res_status = tlpq_pkg::ST_FULL;
				end else begin
					row_load[2] = 1'b1;
					cnt_d[2]    = cnt_q[2] + 1'b1;
					res_id      = key_q;
					res_prio    = 2'(tlpq_pkg::BAJO);
					res_time    = time_q;
				end
			end
			tlpq_pkg::FN_REPRIO: begin
				if (!found) begin
					res_status = tlpq_pkg::ST_NOT_FOUND;
				end else begin
					res_id   = e_id;
					res_time = e_time;
					res_prio = fq + 2'd1;
					if (np_q < tlpq_pkg::ALTO || np_q > tlpq_pkg::BAJO) begin
						res_status = tlpq_pkg::ST_BAD_PRIO;
					end else if (tq != fq && cnt_q[tq] == CntFull) begin
						res_status = tlpq_pkg::ST_FULL;
					end else begin
						row_ctl[fq].shift = 1'b1;
						cnt_d[fq]         = cnt_q[fq] - 1'b1;
						row_load[tq]      = 1'b1;
						load_pos[tq]      = cnt_d[tq];
						cnt_d[tq]         = cnt_d[tq] + 1'b1;
						load_id           = e_id;
						load_time         = e_time;
						res_prio          = 2'(np_q);
					end
				end
			end
			tlpq_pkg::FN_DEQUEUE: begin
				if (!dq_any) begin
					res_status = tlpq_pkg::ST_EMPTY;
				end else begin
					row_ctl[dq].shift     = 1'b1;
					row_ctl[dq].shift_all = 1'b1;
					cnt_d[dq]             = cnt_q[dq] - 1'b1;
					res_id                = c_id[dq][0];
					res_time              = c_time[dq][0];
					res_prio              = dq + 2'd1;
				end
			end
			tlpq_pkg::FN_SEARCH: begin
				if (!found) begin
					res_status = tlpq_pkg::ST_NOT_FOUND;
				end else begin
					res_id   = e_id;
					res_time = e_time;
					res_prio = fq + 2'd1;
				end
			end
			default: begin
				res_status = tlpq_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			for (int r = 0; r < NumQ; r++) begin
				cnt_q[r] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (exec_go) begin
				m_valid_q <= 1'b1;
				for (int r = 0; r < NumQ; r++) begin
					cnt_q[r] <= cnt_d[r];
				end
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= tlpq_pkg::func_t'(s_tdata[1:0]);
			key_q  <= key_in;
			np_q   <= s_tdata[20:18];
			time_q <= s_tdata[37:21];
		end
		if (exec_go) begin
			m_data_q <= {2'b00, res_time, res_prio,
				tlpq_pkg::FID_W'(res_id[KeepW-1:0]), res_status};
		end
	end

endmodule

FILE: rtl/tlpq_checker.sv
`include "three_level_priority_ticket_queue_assert.svh"

module tlpq_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic [tlpq_pkg::IN_W-1:0]  s_tdata,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [tlpq_pkg::OUT_W-1:0] m_tdata
);

	logic [tlpq_pkg::STATUS_W-1:0] st;
	logic                          in_seen;
	logic                          out_stall;
	logic                          out_miss;
	logic                          out_ok;

	assign st        = m_tdata[2:0];
	assign in_seen   = s_tvalid & s_tready;
	assign out_stall = m_tvalid & ~m_tready;
	assign out_miss  = m_tvalid & (st == tlpq_pkg::ST_NOT_FOUND || st == tlpq_pkg::ST_EMPTY);
	assign out_ok    = m_tvalid & (st == tlpq_pkg::ST_OK);

	`TLPQ_ASSERT_NXT(a_out_hold, clk, arst_n, out_stall, $stable({m_tvalid, m_tdata}), "word not held")

	`TLPQ_ASSERT_NXT(a_one_cmd, clk, arst_n, in_seen, !s_tready, "command overlap")

	`TLPQ_ASSERT_IMP(a_miss_zero, clk, arst_n, out_miss, m_tdata[39:3] == '0, "miss with data")

	`TLPQ_ASSERT_IMP(a_ok_prio, clk, arst_n, out_ok, m_tdata[20:19] != 2'd0, "ok without priority")

endmodule

bind three_level_priority_ticket_queue tlpq_checker u_tlpq_checker (.*);

FILE: test/ticket_queue_checker.sv
module ticket_queue_checker
	import tlpq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	// func[1:0], ticket_id[17:2], new_priority[20:18], reg_time[37:21]
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             m_tvalid,
	input  logic             m_tready,
	// status[2:0], found_id[18:3], found_priority[20:19], found_time[37:21]
	input  logic [OUT_W-1:0] m_tdata,
	output int               mismatches,
	output int               pending,
	output int               checked,
	output logic [4:0]       status_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH    = QUEUE_DEPTH_DEF;
	localparam int LOW_LANE = int'(BAJO) - 1;

	typedef struct packed {
		logic [FID_W-1:0]  id;
		logic [TIME_W-1:0] tm;
	} ticket_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FID_W-1:0]    id;
		logic [FPRIO_W-1:0]  prio;
		logic [TIME_W-1:0]   tm;
	} outcome_t;

	ticket_t  lane [NUM_Q][DEPTH];
	int       fill [NUM_Q];
	outcome_t ticket_outcomes [$];

	function automatic void pull_entry(int l, int pos);
		for (int i = pos; i + 1 < fill[l]; i++)
			lane[l][i] = lane[l][i + 1];
		fill[l]--;
	endfunction

	function automatic outcome_t run_ticket_op(logic [IN_W-1:0] word);
		func_t             op;
		logic [FID_W-1:0]  id;
		logic [PRIO_W-1:0] np;
		logic [TIME_W-1:0] tm;
		int                hit_l;
		int                hit_p;
		int                target;
		ticket_t           e;
		outcome_t          r;
		op = func_t'(word[1:0]);
		id = word[17:2];
		np = word[20:18];
		tm = word[37:21];
		r = '0;
		hit_l = -1;
		hit_p = 0;
		case (op)
		FN_REGISTER: begin
			if (fill[LOW_LANE] >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				lane[LOW_LANE][fill[LOW_LANE]] = '{id: id, tm: tm};
				fill[LOW_LANE]++;
				r = '{status: ST_OK, id: id, prio: BAJO[FPRIO_W-1:0], tm: tm};
			end
		end
		FN_DEQUEUE: begin
			for (int l = NUM_Q - 1; l >= 0; l--)
				if (fill[l] > 0)
					hit_l = l;
			if (hit_l < 0) begin
				r.status = ST_EMPTY;
			end else begin
				e = lane[hit_l][0];
				pull_entry(hit_l, 0);
				r = '{status: ST_OK, id: e.id, prio: FPRIO_W'(hit_l + 1), tm: e.tm};
			end
		end
		default: begin
			for (int l = 0; l < NUM_Q && hit_l < 0; l++)
				for (int p = 0; p < fill[l] && hit_l < 0; p++)
					if (lane[l][p].id == id) begin
						hit_l = l;
						hit_p = p;
					end
			if (hit_l < 0) begin
				r.status = ST_NOT_FOUND;
			end else begin
				e = lane[hit_l][hit_p];
				r = '{status: ST_OK, id: e.id, prio: FPRIO_W'(hit_l + 1), tm: e.tm};
				if (op == FN_REPRIO) begin
					if (np < ALTO || np > BAJO) begin
						r.status = ST_BAD_PRIO;
					end else begin
						target = int'(np) - 1;
						if (target != hit_l && fill[target] >= DEPTH) begin
							r.status = ST_FULL;
						end else begin
							pull_entry(hit_l, hit_p);
							lane[target][fill[target]] = e;
							fill[target]++;
							r.prio = np[FPRIO_W-1:0];
						end
					end
				end
			end
		end
		endcase
		return r;
	endfunction

	function automatic void flag_error(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s", $time, msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t got;
		outcome_t want;
		if (!arst_n) begin
			foreach (fill[l])
				fill[l] = 0;
			ticket_outcomes.delete();
			pending = 0;
			checked = 0;
			mismatches = 0;
			status_seen = '0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.status = m_tdata[2:0];
				got.id = m_tdata[18:3];
				got.prio = m_tdata[20:19];
				got.tm = m_tdata[37:21];
				checked++;
				if (ticket_outcomes.size() == 0) begin
					flag_error($sformatf("unexpected word: st=%0d id=%h pr=%0d tm=%0d",
						got.status, got.id, got.prio, got.tm));
				end else begin
					want = ticket_outcomes.pop_front();
					status_seen[want.status] = 1'b1;
					if (got !== want)
						flag_error($sformatf({"mismatch: want st=%0d id=%h pr=%0d tm=%0d, ",
							"got st=%0d id=%h pr=%0d tm=%0d"},
							want.status, want.id, want.prio, want.tm,
							got.status, got.id, got.prio, got.tm));
				end
			end
			if (s_tvalid && s_tready)
				ticket_outcomes.push_back(run_ticket_op(s_tdata));
			pending = ticket_outcomes.size();
		end
	end

endmodule

FILE: test/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tlpq_pkg::*;

	typedef enum int {SC_FILL, SC_MOVE, SC_DRAIN, SC_LOOKUP, SC_NOISE, SC_SATURATE} scenario_t;
	typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_HOLD} rx_mode_t;

	localparam int POOL_SIZE = 24;
	localparam int MAX_TIME  = 86399;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	int         mismatches;
	int         pending;
	int         checked;
	logic [4:0] status_seen;

	int          burst_left = 0;
	int          sent = 0;
	int          op_count [4] = '{default: 0};
	logic        hold_request = 1'b0;
	logic        hold_started = 1'b0;
	logic [15:0] id_pool [POOL_SIZE];

	three_level_priority_ticket_queue DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	ticket_queue_checker queue_watch (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.pending     (pending),
		.checked     (checked),
		.status_seen (status_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic logic [15:0] pick_id();
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom_range(0, 65535));
		return id_pool[$urandom_range(0, POOL_SIZE - 1)];
	endfunction

	function automatic logic [2:0] any_prio();
		return 3'($urandom_range(0, 7));
	endfunction

	function automatic logic [16:0] any_time();
		return 17'($urandom_range(0, MAX_TIME));
	endfunction

	task automatic issue(input func_t op, input logic [15:0] id, input logic [2:0] np,
			input logic [16:0] tm);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 10);
		end
		burst_left--;
		s_tdata <= {2'b00, tm, np, id, op};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		op_count[int'(op)]++;
		sent++;
		@(negedge clk);
	endtask

	// hold off until every outstanding word has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
	endtask

	task automatic saturate();
		logic [2:0] t;
		t = ($urandom_range(0, 1) == 0) ? ALTO : MEDIO;
		for (int i = 0; i <= QUEUE_DEPTH_DEF; i++)
			issue(FN_REGISTER, id_pool[i], any_prio(), any_time());
		for (int i = 0; i <= QUEUE_DEPTH_DEF; i++)
			issue(FN_REPRIO, id_pool[i], t, any_time());
		issue(FN_REGISTER, id_pool[QUEUE_DEPTH_DEF], any_prio(), any_time());
		issue(FN_REPRIO, id_pool[QUEUE_DEPTH_DEF], t, any_time());
	endtask

	initial begin
		rx_mode_t mode;
		int len;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_request && !hold_started) begin
				hold_started = 1'b1;
				mode = RX_HOLD;
				len = 100;
			end else begin
				mode = rx_mode_t'($urandom_range(int'(RX_OPEN), int'(RX_MOSTLY)));
				len = $urandom_range(10, 80);
			end
			repeat (len) begin
				@(negedge clk);
				case (mode)
				RX_OPEN: m_tready <= 1'b1;
				RX_COIN: m_tready <= ($urandom_range(0, 1) == 0);
				RX_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
				default: m_tready <= 1'b0;
				endcase
			end
		end
	end

	initial begin
		scenario_t sc;
		int pick;
		int n;
		logic [2:0] np;
		for (int i = 0; i < POOL_SIZE; i++)
			id_pool[i] = 16'(($urandom_range(0, 2047) << 5) | i);
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		issue(FN_DEQUEUE, 16'hFFFF, 3'd7, 17'(MAX_TIME));
		issue(FN_SEARCH, 16'h0000, 3'd0, 17'd0);
		issue(FN_REPRIO, 16'hFFFF, ALTO, 17'd0);
		issue(FN_REGISTER, 16'h0000, 3'd7, 17'd0);
		issue(FN_REGISTER, 16'hFFFF, 3'd0, 17'(MAX_TIME));
		issue(FN_REGISTER, 16'h1234, BAJO, 17'd43200);
		issue(FN_SEARCH, 16'hFFFF, 3'd7, 17'd0);
		issue(FN_REPRIO, 16'hFFFF, 3'd0, 17'd0);
		issue(FN_REPRIO, 16'hFFFF, 3'd7, 17'd0);
		issue(FN_REPRIO, 16'hFFFF, ALTO, 17'(MAX_TIME));
		issue(FN_REPRIO, 16'h0000, MEDIO, 17'd0);
		issue(FN_REPRIO, 16'h1234, BAJO, 17'd0);
		issue(FN_SEARCH, 16'h0000, 3'd0, 17'd0);
		issue(FN_REPRIO, 16'hFFFF, ALTO, 17'd0);
		issue(FN_REPRIO, 16'h0000, 3'd4, 17'd0);
		issue(FN_SEARCH, 16'h1234, 3'd0, 17'd0);
		issue(FN_DEQUEUE, 16'h0000, 3'd0, 17'd0);
		issue(FN_DEQUEUE, 16'h0000, 3'd0, 17'd0);
		issue(FN_DEQUEUE, 16'h0000, 3'd0, 17'd0);
		issue(FN_DEQUEUE, 16'h0000, 3'd0, 17'd0);

		settle();
		saturate();

		s_tvalid <= 1'b0;
		hold_request = 1'b1;
		@(negedge clk);
		while (!hold_started) @(negedge clk);
		burst_left = 40;
		repeat (30)
			issue(func_t'($urandom_range(0, 3)), pick_id(), any_prio(), any_time());

		while (sent < 500) begin
			if ($urandom_range(0, 5) == 0)
				settle();
			pick = $urandom_range(0, 9);
			sc = pick < 3 ? SC_FILL : pick < 6 ? SC_MOVE : pick < 7 ? SC_DRAIN
				: pick < 8 ? SC_LOOKUP : pick < 9 ? SC_NOISE : SC_SATURATE;
			n = $urandom_range(1, 20);
			case (sc)
			SC_FILL: begin
				repeat (n)
					issue(FN_REGISTER, pick_id(), any_prio(), any_time());
			end
			SC_MOVE: begin
				repeat (n) begin
					np = ($urandom_range(0, 4) == 0) ? any_prio()
						: 3'($urandom_range(int'(ALTO), int'(BAJO)));
					issue(FN_REPRIO, pick_id(), np, any_time());
				end
			end
			SC_DRAIN: begin
				repeat ($urandom_range(1, 24))
					issue(FN_DEQUEUE, pick_id(), any_prio(), any_time());
			end
			SC_LOOKUP: begin
				repeat (n)
					issue(FN_SEARCH, pick_id(), any_prio(), any_time());
			end
			SC_NOISE: begin
				repeat (n)
					issue(func_t'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
						any_prio(), any_time());
			end
			default: saturate();
			endcase
		end

		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		$display({"%0d commands (%0d register, %0d reprioritize, %0d dequeue, ",
			"%0d search), %0d checked"},
			sent, op_count[int'(FN_REGISTER)], op_count[int'(FN_REPRIO)],
			op_count[int'(FN_DEQUEUE)], op_count[int'(FN_SEARCH)], checked);
		$display("statuses seen (bad priority, full, empty, not found, ok): %b", status_seen);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
